// ===== rtl/brac_pkg.sv =====
// Shared types and constants for the block range add and count engine.
package brac_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 11;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Register byte addresses on the configuration port.
   localparam logic [CSR_AW-1:0] CSR_ELEMENT_COUNT = 3'd0;
   localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_COUNT = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Operands for the shared add and compare unit.
   typedef struct packed {
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic [DATA_W-1:0] threshold;
   } alu_req_type;

endpackage

// ===== rtl/block_range_add_count_at_least.sv =====
// Range add and range count of values at or above a threshold over a block-tagged array.
// Loads write the store directly and the block stays ready. A range add or range count walks the
// array block by block from block zero up to the block holding the clamped range end,
// plus a closing block check: each block takes a block step, and each element that must be
// touched one by one (every element of a count range, and the elements of a partly covered
// block of an add) takes a read step for the registered memory read and an execute step for the
// shared adder. A whole block under an add only has the operand added to its tag. A count
// result is then registered in a finish step, which waits while an earlier result is stalled.
// Only a range count returns a transfer on the rsp channel.
module block_range_add_count_at_least #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int BLOCK_LEN    = 32,
   parameter int NUM_BLOCKS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brac_pkg::ACTION_W-1:0] req_action,
   input  logic [brac_pkg::INDEX_W-1:0]  req_first_index,
   input  logic [brac_pkg::INDEX_W-1:0]  req_last_index,
   input  logic signed [brac_pkg::DATA_W-1:0] req_operand_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brac_pkg::COUNT_W-1:0]  rsp_match_count,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [brac_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [brac_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [brac_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import brac_pkg::*;

   localparam int AW  = $clog2(MAX_ELEMENTS);
   localparam int TW  = $clog2(NUM_BLOCKS);
   localparam int BWR = $clog2(MAX_ELEMENTS + BLOCK_LEN) + 1;
   localparam int BW  = (BWR > COUNT_W + 1) ? BWR : COUNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLOCK,
      ST_READ,
      ST_EXEC,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   action_type         act_ff;
   logic [BW-1:0]      first_ff;
   logic [BW-1:0]      hi_ff;
   logic [BW-1:0]      lim_ff;
   logic [DATA_W-1:0]  x_ff;
   logic [BW-1:0]      bs_ff;
   logic [BW-1:0]      blk_ff;
   logic [BW-1:0]      idx_ff;
   logic [BW-1:0]      seg_end_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] element_count_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [DATA_W-1:0]  tag_ff [NUM_BLOCKS];

   logic               req_accept;
   action_type         req_act;
   logic [BW-1:0]      req_first;
   logic [BW-1:0]      req_last;
   logic [BW-1:0]      lim_in;
   logic [BW-1:0]      hi_in;
   logic [BW-1:0]      be_full;
   logic [BW-1:0]      be;
   logic               blk_tagged;
   logic [DATA_W-1:0]  blk_tag;
   logic               whole_blk;
   alu_req_type        alu_req;
   logic [DATA_W-1:0]  alu_sum;
   logic               alu_ge;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [DATA_W-1:0]  mem_wr_data;
   logic [DATA_W-1:0]  mem_rd_data;
   logic               csr_write;

   // Input and configuration decode.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_act    = action_type'(req_action);
   assign req_first  = BW'(req_first_index);
   assign req_last   = BW'(req_last_index);
   assign lim_in     = (BW'(element_count_ff) > BW'(MAX_ELEMENTS)) ?
                       BW'(MAX_ELEMENTS) : BW'(element_count_ff);
   assign hi_in      = (lim_in != '0 && req_last >= lim_in) ? lim_in - 1'b1 : req_last;

   // Current block bounds and its tag.
   assign be_full    = bs_ff + BW'(BLOCK_LEN - 1);
   assign be         = (be_full >= lim_ff) ? lim_ff - 1'b1 : be_full;
   assign blk_tagged = blk_ff < BW'(NUM_BLOCKS);
   assign blk_tag    = blk_tagged ? tag_ff[blk_ff[TW-1:0]] : '0;
   assign whole_blk  = (act_ff == ACT_ADD) && blk_tagged && (bs_ff >= first_ff) &&
                       (be <= hi_ff);

   // Operand selection for the shared unit.
   always_comb begin
      alu_req.threshold = x_ff;
      alu_req.operand_a = mem_rd_data;
      alu_req.operand_b = (act_ff == ACT_ADD) ? x_ff : blk_tag;
      if (state_ff == ST_BLOCK) begin
         alu_req.operand_a = blk_tag;
         alu_req.operand_b = x_ff;
      end
   end

   brac_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum),
      .alu_ge  (alu_ge)
   );

   // Memory write: a load in idle, or an element add while executing.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = alu_sum;
      if (state_ff == ST_IDLE) begin
         mem_wr_en   = req_accept && (req_act == ACT_LOAD) && (req_first < lim_in);
         mem_wr_addr = req_first[AW-1:0];
         mem_wr_data = req_operand_value;
      end else if (state_ff == ST_EXEC) begin
         mem_wr_en   = (act_ff == ACT_ADD);
      end
   end

   brac_store #(
      .DEPTH (MAX_ELEMENTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_ELEMENT_COUNT);
   assign csr_prdata = (csr_paddr == CSR_ELEMENT_COUNT) ? CSR_DW'(element_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= ELEMENT_COUNT_RESET;
      end else if (csr_write) begin
         element_count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   // Sequencer with its registered outputs and block tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_act == ACT_ADD || req_act == ACT_COUNT)) begin
                  act_ff   <= req_act;
                  first_ff <= req_first;
                  hi_ff    <= hi_in;
                  lim_ff   <= lim_in;
                  x_ff     <= req_operand_value;
                  bs_ff    <= '0;
                  blk_ff   <= '0;
                  idx_ff   <= '0;
                  cnt_ff   <= '0;
                  if (lim_in == '0 || req_first > hi_in) begin
                     state_ff <= (req_act == ACT_COUNT) ? ST_FINISH : ST_IDLE;
                  end else begin
                     state_ff <= ST_BLOCK;
                  end
               end
            end
            ST_BLOCK: begin
               if (bs_ff > hi_ff) begin
                  state_ff <= (act_ff == ACT_COUNT) ? ST_FINISH : ST_IDLE;
               end else if (whole_blk || be < first_ff) begin
                  if (whole_blk) begin
                     tag_ff[blk_ff[TW-1:0]] <= alu_sum;
                  end
                  bs_ff  <= bs_ff + BW'(BLOCK_LEN);
                  blk_ff <= blk_ff + 1'b1;
               end else begin
                  idx_ff     <= (bs_ff > first_ff) ? bs_ff : first_ff;
                  seg_end_ff <= (be < hi_ff) ? be : hi_ff;
                  state_ff   <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (act_ff == ACT_COUNT && alu_ge) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (idx_ff == seg_end_ff) begin
                  bs_ff    <= bs_ff + BW'(BLOCK_LEN);
                  blk_ff   <= blk_ff + 1'b1;
                  state_ff <= ST_BLOCK;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= cnt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule

// ===== rtl/brac_alu.sv =====
// Shared 32-bit adder with a signed at-or-above compare on its sum.
module brac_alu (
   input  brac_pkg::alu_req_type        alu_req,
   output logic [brac_pkg::DATA_W-1:0]  alu_sum,
   output logic                         alu_ge
);
   import brac_pkg::*;

   // Wrapping add, then a signed compare of the sum against the threshold.
   assign alu_sum = alu_req.operand_a + alu_req.operand_b;
   assign alu_ge  = $signed(alu_sum) >= $signed(alu_req.threshold);

endmodule

// ===== rtl/brac_store.sv =====
// Element value memory: one write port and one registered read port.
module brac_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [brac_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [brac_pkg::DATA_W-1:0] rd_data
);
   import brac_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/brac_checker.sv =====
// Port-level checks for the range add and count engine, bound to its top level.
module brac_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [brac_pkg::COUNT_W-1:0] rsp_match_count
);
   import brac_pkg::*;

   // A waiting result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transfer dropped while stalled");

   // A waiting result keeps its count.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_match_count))
      else $error("result count changed while stalled");

   // No result is offered right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result only appears at the end of a busy period.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a range count in progress");

endmodule

bind block_range_add_count_at_least brac_checker u_brac_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_match_count (rsp_match_count)
);
